FILE: design/pwmd_pkg.sv
// Shared types and constants for the peer wire message deframer.
// No dependencies.
package pwmd_pkg;

	localparam int unsigned HS_LAST = 67;
	localparam logic [7:0] PROTO_LEN = 8'd19;
	localparam logic [6:0] HASH_FIRST = 7'd28;
	localparam logic [6:0] HASH_END = 7'd48;
	localparam logic [16:0] PIECE_MIN = 17'd9;
	localparam logic [6:0] PIECE_HDR_LAST = 7'd7;
	localparam logic [6:0] PIECE_INDEX_BYTES = 7'd4;
	localparam logic [6:0] PREFIX_LAST = 7'd3;

	localparam logic [7:0] ID_CHOKE = 8'd0;
	localparam logic [7:0] ID_UNCHOKE = 8'd1;
	localparam logic [7:0] ID_BITFIELD = 8'd5;
	localparam logic [7:0] ID_PIECE = 8'd7;

	localparam logic [2:0] EV_HS_OK = 3'd0;
	localparam logic [2:0] EV_KEEPALIVE = 3'd1;
	localparam logic [2:0] EV_MSG_START = 3'd2;
	localparam logic [2:0] EV_PAYLOAD = 3'd3;
	localparam logic [2:0] EV_PIECE_HDR = 3'd4;
	localparam logic [2:0] EV_CLOSED = 3'd5;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_HANDSHAKE = 3'd1;
	localparam logic [2:0] ERR_OVERSIZE = 3'd2;
	localparam logic [2:0] ERR_BITFIELD = 3'd3;
	localparam logic [2:0] ERR_SHORT_PIECE = 3'd4;

	localparam logic [2:0] REG_HASH_HIGH = 3'd0;
	localparam logic [2:0] REG_HASH_MID = 3'd1;
	localparam logic [2:0] REG_HASH_LOW = 3'd2;
	localparam logic [2:0] REG_PIECE_COUNT = 3'd3;
	localparam logic [2:0] REG_CHUNK_LOG2 = 3'd4;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [2:0]  error_code;
		logic [7:0]  message_id;
		logic [15:0] message_length;
		logic [7:0]  payload_value;
		logic        final_of_message;
		logic        choked_now;
		logic [31:0] piece_number;
		logic [31:0] piece_offset;
		logic        piece_acceptable;
	} result_t;

	// protocol string, character k
	function automatic logic [7:0] proto_char(input logic [4:0] k);
		logic [7:0] c;
		case (k)
			5'd0: c = "B";
			5'd1: c = "i";
			5'd2: c = "t";
			5'd3: c = "T";
			5'd4: c = "o";
			5'd5: c = "r";
			5'd6: c = "r";
			5'd7: c = "e";
			5'd8: c = "n";
			5'd9: c = "t";
			5'd10: c = " ";
			5'd11: c = "p";
			5'd12: c = "r";
			5'd13: c = "o";
			5'd14: c = "t";
			5'd15: c = "o";
			5'd16: c = "c";
			5'd17: c = "o";
			5'd18: c = "l";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

endpackage

FILE: design/peer_wire_message_deframer.sv
// Peer wire message deframer top level: handshake check, length-prefixed
// message parsing and result output with a skid stage. Depends on pwmd_pkg.
//
// One received byte per word on the byte channel; at most one result word per
// byte on the event channel. Each byte is parsed in the cycle it is accepted
// and its result is registered, so the block takes one byte every cycle while
// the skid register is empty; a two-entry output (result register plus skid
// register) keeps it taking bytes while event_ready is low until a second
// result word is waiting. The first 68 bytes are the handshake; after it,
// messages with a 4-byte big-endian length prefix are parsed. A bad handshake,
// a length above BUFFER_BYTES - 4, a bitfield of the wrong size or a short
// piece reports a closed event and all later bytes are dropped until reset.
// Registers are written through wr_en/wr_index/wr_data; the user must write
// them only while the block is idle, as the block itself does not enforce it.
module peer_wire_message_deframer
	import pwmd_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [63:0] wr_data,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	output logic        event_valid,
	input  logic        event_ready,
	output logic [2:0]  event_kind,
	output logic [2:0]  error_code,
	output logic [7:0]  message_id,
	output logic [15:0] message_length,
	output logic [7:0]  payload_value,
	output logic        final_of_message,
	output logic        choked_now,
	output logic [31:0] piece_number,
	output logic [31:0] piece_offset,
	output logic        piece_acceptable
);

	localparam logic [31:0] MAX_LEN = 32'(BUFFER_BYTES - 4);

	localparam logic [2:0] PH_HANDSHAKE = 3'd0;
	localparam logic [2:0] PH_LENGTH = 3'd1;
	localparam logic [2:0] PH_ID = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_CLOSED = 3'd4;

	logic [63:0] hash_high_q, hash_mid_q;
	logic [31:0] hash_low_q;
	logic [20:0] piece_count_q;
	logic [4:0]  chunk_log2_q;

	logic [2:0]  phase_q, phase_d;
	logic [6:0]  pos_q, pos_d;
	logic        match_q, match_d;
	logic [31:0] len_q, len_d;
	logic [7:0]  id_q, id_d;
	logic [16:0] rem_q, rem_d;
	logic        choked_q, choked_d;
	logic [31:0] idx_q, idx_d;
	logic [31:0] beg_q, beg_d;

	result_t     res, out_q, skid_q;
	logic        res_v, out_v_q, skid_v_q;
	logic        accept, out_free;

	logic [19:0][7:0] hash_bytes;
	logic [4:0]  hash_k;
	logic [16:0] rem_id;
	logic [18:0] bf_expected;
	logic [16:0] block_len;
	logic        size_ok, align_ok;
	logic [31:0] align_mask;
	logic        bad;

	assign byte_ready = !skid_v_q;
	assign accept = byte_valid && byte_ready;
	assign out_free = !out_v_q || event_ready;

	assign hash_bytes = {hash_high_q, hash_mid_q, hash_low_q};
	assign hash_k = 5'(pos_q - HASH_FIRST);
	assign rem_id = 17'(len_q - 32'd1);
	assign bf_expected = 19'((22'(piece_count_q) + 22'd7) >> 3);
	assign block_len = len_q[16:0] - PIECE_MIN;
	assign size_ok = (chunk_log2_q > 5'd16) || ({1'b0, block_len} <= (18'd1 << chunk_log2_q));
	assign align_mask = 32'((33'd1 << chunk_log2_q) - 33'd1);
	assign align_ok = (beg_d & align_mask) == 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_high_q <= '0;
			hash_mid_q <= '0;
			hash_low_q <= '0;
			piece_count_q <= 21'd1;
			chunk_log2_q <= 5'd14;
		end else if (wr_en) begin
			case (wr_index)
				REG_HASH_HIGH: hash_high_q <= wr_data;
				REG_HASH_MID: hash_mid_q <= wr_data;
				REG_HASH_LOW: hash_low_q <= wr_data[31:0];
				REG_PIECE_COUNT: piece_count_q <= wr_data[20:0];
				REG_CHUNK_LOG2: chunk_log2_q <= wr_data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		match_d = match_q;
		len_d = len_q;
		id_d = id_q;
		rem_d = rem_q;
		choked_d = choked_q;
		idx_d = idx_q;
		beg_d = beg_q;
		res_v = 1'b0;
		res = '0;
		bad = 1'b0;
		case (phase_q)
			PH_HANDSHAKE: begin
				if (pos_q == 7'd0) begin
					bad = data_byte != PROTO_LEN;
				end else if (pos_q <= 7'(PROTO_LEN)) begin
					bad = data_byte != proto_char(5'(pos_q - 7'd1));
				end else if (pos_q >= HASH_FIRST && pos_q < HASH_END) begin
					bad = data_byte != hash_bytes[5'd19 - hash_k];
				end
				match_d = match_q && !bad;
				if (pos_q == 7'(HS_LAST)) begin
					pos_d = '0;
					res_v = 1'b1;
					if (!match_d) begin
						phase_d = PH_CLOSED;
						res.event_kind = EV_CLOSED;
						res.error_code = ERR_HANDSHAKE;
					end else begin
						phase_d = PH_LENGTH;
						len_d = '0;
						res.event_kind = EV_HS_OK;
					end
				end else begin
					pos_d = pos_q + 7'd1;
				end
			end
			PH_LENGTH: begin
				len_d = {len_q[23:0], data_byte};
				if (pos_q == PREFIX_LAST) begin
					pos_d = '0;
					if (len_d == 32'd0) begin
						res_v = 1'b1;
						res.event_kind = EV_KEEPALIVE;
						res.final_of_message = 1'b1;
					end else if (len_d > MAX_LEN) begin
						res_v = 1'b1;
						phase_d = PH_CLOSED;
						res.event_kind = EV_CLOSED;
						res.error_code = ERR_OVERSIZE;
					end else begin
						phase_d = PH_ID;
					end
				end else begin
					pos_d = pos_q + 7'd1;
				end
			end
			PH_ID: begin
				id_d = data_byte;
				rem_d = rem_id;
				res_v = 1'b1;
				if (data_byte == ID_BITFIELD && {2'b00, rem_id} != bf_expected) begin
					phase_d = PH_CLOSED;
					res.event_kind = EV_CLOSED;
					res.error_code = ERR_BITFIELD;
				end else if (data_byte == ID_PIECE && rem_id < PIECE_MIN) begin
					phase_d = PH_CLOSED;
					res.event_kind = EV_CLOSED;
					res.error_code = ERR_SHORT_PIECE;
				end else begin
					if (data_byte == ID_CHOKE) choked_d = 1'b1;
					if (data_byte == ID_UNCHOKE) choked_d = 1'b0;
					res.event_kind = EV_MSG_START;
					res.message_id = data_byte;
					res.message_length = len_q[15:0];
					res.final_of_message = rem_id == 17'd0;
					if (rem_id == 17'd0) begin
						phase_d = PH_LENGTH;
						len_d = '0;
					end else begin
						phase_d = PH_PAYLOAD;
						pos_d = '0;
						idx_d = '0;
						beg_d = '0;
					end
				end
			end
			PH_PAYLOAD: begin
				rem_d = rem_q - 17'd1;
				res.message_id = id_q;
				res.message_length = len_q[15:0];
				if (id_q == ID_PIECE && pos_q <= PIECE_HDR_LAST) begin
					if (pos_q < PIECE_INDEX_BYTES) idx_d = {idx_q[23:0], data_byte};
					else beg_d = {beg_q[23:0], data_byte};
					pos_d = pos_q + 7'd1;
					if (pos_q == PIECE_HDR_LAST) begin
						res_v = 1'b1;
						res.event_kind = EV_PIECE_HDR;
						res.piece_number = idx_d;
						res.piece_offset = beg_d;
						res.piece_acceptable = size_ok && align_ok;
					end
				end else begin
					res_v = 1'b1;
					res.event_kind = EV_PAYLOAD;
					res.payload_value = data_byte;
					res.final_of_message = rem_d == 17'd0;
				end
				if (rem_d == 17'd0) begin
					phase_d = PH_LENGTH;
					len_d = '0;
					pos_d = '0;
				end
			end
			default: ;
		endcase
		res.choked_now = choked_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HANDSHAKE;
			pos_q <= '0;
			match_q <= 1'b1;
			len_q <= '0;
			id_q <= '0;
			rem_q <= '0;
			choked_q <= 1'b1;
			idx_q <= '0;
			beg_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			match_q <= match_d;
			len_q <= len_d;
			id_q <= id_d;
			rem_q <= rem_d;
			choked_q <= choked_d;
			idx_q <= idx_d;
			beg_q <= beg_d;
		end
	end

	// result register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept && res_v;
			end
		end else if (accept && res_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (accept && res_v) begin
			skid_q <= res;
		end
	end

	assign event_valid = out_v_q;
	assign event_kind = out_q.event_kind;
	assign error_code = out_q.error_code;
	assign message_id = out_q.message_id;
	assign message_length = out_q.message_length;
	assign payload_value = out_q.payload_value;
	assign final_of_message = out_q.final_of_message;
	assign choked_now = out_q.choked_now;
	assign piece_number = out_q.piece_number;
	assign piece_offset = out_q.piece_offset;
	assign piece_acceptable = out_q.piece_acceptable;

endmodule
